FILE: src/assert_macros.svh
// assertion macros shared by the mandelbrot pixel core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

FILE: src/mbrot_pkg.sv
// shared types, constants and the ln table of the mandelbrot pixel core
`default_nettype none

package mbrot_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 28;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL,
    REG_ORIGIN_IMAG,
    REG_STEP_REAL,
    REG_STEP_IMAG,
    REG_ITER_LIMIT
  } cfg_reg_t;

  // register reset values
  localparam logic signed [31:0] ORIGIN_REAL_RST = -32'sd644245094;
  localparam logic signed [31:0] ORIGIN_IMAG_RST = -32'sd322122547;
  localparam logic signed [31:0] STEP_REAL_RST   = 32'sd1342177;
  localparam logic signed [31:0] STEP_IMAG_RST   = 32'sd1342177;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST  = 16'd100;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one point c of the complex plane
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cpoint_t;

  // queue fill status
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // iteration sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MULT,
    ST_LOG,
    ST_COLOR
  } back_state_t;

  // round(256 * ln(n)), entries 0 and 1 are zero
  localparam logic [10:0] LN_Q8 [64] = '{
    11'd0,    11'd0,    11'd177,  11'd281,  11'd355,  11'd412,  11'd459,  11'd498,
    11'd532,  11'd562,  11'd589,  11'd614,  11'd636,  11'd657,  11'd676,  11'd693,
    11'd710,  11'd725,  11'd740,  11'd754,  11'd767,  11'd779,  11'd791,  11'd803,
    11'd814,  11'd824,  11'd834,  11'd844,  11'd853,  11'd862,  11'd871,  11'd879,
    11'd887,  11'd895,  11'd903,  11'd910,  11'd917,  11'd924,  11'd931,  11'd938,
    11'd944,  11'd951,  11'd957,  11'd963,  11'd969,  11'd975,  11'd980,  11'd986,
    11'd991,  11'd996,  11'd1001, 11'd1007, 11'd1012, 11'd1016, 11'd1021, 11'd1026,
    11'd1030, 11'd1035, 11'd1039, 11'd1044, 11'd1048, 11'd1052, 11'd1057, 11'd1061
  };

endpackage

`default_nettype wire

FILE: src/mbrot_front.sv
// front end: configuration registers and mapping of a pixel to the point c
`default_nettype none

module mbrot_front #(
  parameter int COORD_BITS = mbrot_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           column,
  input  logic [COORD_BITS-1:0]           row,
  input  logic                            cfg_we,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mbrot_pkg::qstat_t               qstat,
  output logic                            push,
  output mbrot_pkg::cpoint_t              point,
  output logic [mbrot_pkg::LIMIT_W-1:0]   iteration_limit
);
  import mbrot_pkg::*;

  localparam int PROD_W = COORD_BITS + 33;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [31:0]       origin_real;
  logic signed [31:0]       origin_imag;
  logic signed [31:0]       step_real;
  logic signed [31:0]       step_imag;
  logic                     accept;
  logic                     pend;
  logic [QCNT_W:0]          occupancy;
  logic signed [COORD_BITS:0] col_s;
  logic signed [COORD_BITS:0] row_s;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;

  // clamp a wide sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-32:0] top;
    top = v[SUM_W-1:31];
    if ((&top) || !(|top)) begin
      sat32 = v[31:0];
    end else if (v[SUM_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real     <= ORIGIN_REAL_RST;
      origin_imag     <= ORIGIN_IMAG_RST;
      step_real       <= STEP_REAL_RST;
      step_imag       <= STEP_IMAG_RST;
      iteration_limit <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_REAL: origin_real     <= cfg_data[31:0];
        REG_ORIGIN_IMAG: origin_imag     <= cfg_data[31:0];
        REG_STEP_REAL:   step_real       <= cfg_data[31:0];
        REG_STEP_IMAG:   step_imag       <= cfg_data[31:0];
        REG_ITER_LIMIT:  iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off new transactions while the queue could run full
  assign occupancy = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, pend};
  assign busy      = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  // stage one: index times step
  assign col_s = {1'b0, column};
  assign row_s = {1'b0, row};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_re <= col_s * step_real;
      prod_im <= row_s * step_imag;
    end
  end

  // stage two: add the origin, saturate and hand to the queue
  assign sum_re   = SUM_W'(origin_real) + SUM_W'(prod_re);
  assign sum_im   = SUM_W'(origin_imag) + SUM_W'(prod_im);
  assign push     = pend;
  assign point.re = sat32(sum_re);
  assign point.im = sat32(sum_im);

endmodule

`default_nettype wire

FILE: src/mbrot_queue.sv
// short queue of points between the front end and the iteration engine
`default_nettype none
`include "assert_macros.svh"

module mbrot_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbrot_pkg::cpoint_t wdata,
  input  logic               pop,
  output mbrot_pkg::cpoint_t rdata,
  output mbrot_pkg::qstat_t  stat
);
  import mbrot_pkg::*;

  cpoint_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata      = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

  `ASSERT_NEVER(q_no_overflow, clk, rst, push && !pop && count == QCNT_W'(QUEUE_DEPTH), "push into full queue")
  `ASSERT_NEVER(q_no_underflow, clk, rst, pop && count == '0, "pop from empty queue")
  `ASSERT_CLK(q_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "count did not follow push")

endmodule

`default_nettype wire

FILE: src/mbrot_back.sv
// iteration engine: z = z*z + c escape loop and smooth color
`default_nettype none
`include "assert_macros.svh"

module mbrot_back #(
  parameter int FRACTION_BITS = mbrot_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mbrot_pkg::LIMIT_W-1:0] iteration_limit,
  input  mbrot_pkg::cpoint_t            qhead,
  input  mbrot_pkg::qstat_t             qstat,
  output logic                          pop,
  output logic                          done,
  output logic [15:0]                   iterations,
  output logic                          inside_res,
  output logic [18:0]                   color
);
  import mbrot_pkg::*;

  // magnitude bound of z between iterations, and derived widths
  localparam int MAG_W = (FRACTION_BITS >= 30) ? FRACTION_BITS + 3 :
                         ((FRACTION_BITS == 29) ? 33 : 32);
  localparam int ZW    = MAG_W + 1;
  localparam int SQ_W  = 2 * MAG_W - FRACTION_BITS;
  localparam int PW    = SQ_W + 2;
  localparam int NW    = PW + 1;
  localparam int WH_W  = SQ_W + 1 - FRACTION_BITS;
  localparam logic [SQ_W:0] FOUR = (SQ_W + 1)'(1) << (FRACTION_BITS + 2);

  back_state_t           state;
  back_state_t           state_next;
  logic signed [31:0]    cr;
  logic signed [31:0]    ci;
  logic signed [ZW-1:0]  zr;
  logic signed [ZW-1:0]  zi;
  logic [SQ_W-1:0]       sr;
  logic [SQ_W-1:0]       si;
  logic signed [PW-1:0]  p;
  logic [LIMIT_W-1:0]    k;
  logic [LIMIT_W-1:0]    esc_k;
  logic [SQ_W:0]         abs2;
  logic [SQ_W:0]         abs2_q;
  logic [13:0]           ln5;
  logic signed [2*ZW-1:0] prod_rr;
  logic signed [2*ZW-1:0] prod_ii;
  logic signed [2*ZW-1:0] prod_ri;
  logic signed [NW-1:0]  nr;
  logic signed [NW-1:0]  ni;
  logic                  escape;
  logic                  at_limit;
  logic [WH_W-1:0]       whole;
  logic [5:0]            lg;
  logic [18:0]           kp1;
  logic [18:0]           base;
  logic [26:0]           scaled;
  logic                  do_load;
  logic                  do_mult;
  logic                  do_update;
  logic                  do_escape;
  logic                  do_log;
  logic                  emit_inside;
  logic                  emit_color;

  // loop tests on the current z
  assign abs2     = {1'b0, sr} + {1'b0, si};
  assign escape   = (k != '0) && (abs2 >= FOUR);
  assign at_limit = k >= iteration_limit;

  // next z from the squares and cross product of the current z
  assign nr = NW'(signed'({1'b0, sr})) - NW'(signed'({1'b0, si})) + NW'(cr);
  assign ni = NW'(p) + NW'(ci);

  // squares and cross product, floor shifted
  assign prod_rr = zr * zr;
  assign prod_ii = zi * zi;
  assign prod_ri = zr * zi;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!qstat.empty) state_next = ST_STEP;
      ST_STEP: begin
        if (escape) begin
          state_next = ST_LOG;
        end else if (at_limit) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MULT;
        end
      end
      ST_MULT:  state_next = ST_STEP;
      ST_LOG:   state_next = ST_COLOR;
      ST_COLOR: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    do_load     = 1'b0;
    do_mult     = 1'b0;
    do_update   = 1'b0;
    do_escape   = 1'b0;
    do_log      = 1'b0;
    emit_inside = 1'b0;
    emit_color  = 1'b0;
    unique case (state)
      ST_IDLE:  do_load = !qstat.empty;
      ST_STEP: begin
        do_escape   = escape;
        emit_inside = !escape && at_limit;
        do_update   = !escape && !at_limit;
      end
      ST_MULT:  do_mult = 1'b1;
      ST_LOG:   do_log = 1'b1;
      ST_COLOR: emit_color = 1'b1;
      default: ;
    endcase
  end

  assign pop = do_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (do_load) begin
      cr <= qhead.re;
      ci <= qhead.im;
      zr <= '0;
      zi <= '0;
      sr <= '0;
      si <= '0;
      p  <= '0;
      k  <= '0;
    end
    if (do_update) begin
      zr <= nr[ZW-1:0];
      zi <= ni[ZW-1:0];
      k  <= k + 1'b1;
    end
    if (do_mult) begin
      sr <= prod_rr[FRACTION_BITS +: SQ_W];
      si <= prod_ii[FRACTION_BITS +: SQ_W];
      p  <= prod_ri[FRACTION_BITS - 1 +: PW];
    end
    if (do_escape) begin
      abs2_q <= abs2;
      esc_k  <= k - 1'b1;
    end
  end

  // integer log2 of the escape magnitude
  assign whole = abs2_q[SQ_W:FRACTION_BITS];

  always_comb begin
    lg = '0;
    for (int i = 1; i < WH_W; i++) begin
      if (whole[i]) lg = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (do_log) begin
      ln5 <= ({3'b000, LN_Q8[lg]} << 2) + {3'b000, LN_Q8[lg]};
    end
  end

  // smooth color: 255 + 5*(k+1) - 5*ln, in 8 fraction bits
  assign kp1    = {3'b000, esc_k} + 19'd1;
  assign base   = 19'd255 + (kp1 << 2) + kp1;
  assign scaled = {base, 8'd0} - {13'd0, ln5};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit_inside || emit_color;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_inside) begin
      iterations <= k;
      inside_res <= 1'b1;
      color      <= '0;
    end else if (emit_color) begin
      iterations <= esc_k;
      inside_res <= 1'b0;
      color      <= scaled[26:8];
    end
  end

  `ASSERT_CLK(b_done_src, clk, rst, done |-> ($past(state) == ST_COLOR || $past(state) == ST_STEP), "result without finishing state")
  `ASSERT_CLK(b_k_bound, clk, rst, (state == ST_STEP) |-> (k <= iteration_limit), "iteration count past limit")
  `ASSERT_CLK(b_inside_black, clk, rst, (done && inside_res) |-> (color == '0), "inside point with nonzero color")

endmodule

`default_nettype wire

FILE: src/mandelbrot_escape_time_pixel_core.sv
// top level of the mandelbrot escape time pixel core with smooth coloring
//
//   channel   signals                               direction  handshake
//   pixel     start busy column row                 in         start && !busy
//   result    done iterations inside_res color      out        done, one cycle
//   config    cfg_we cfg_index cfg_data             in         cfg_we, no wait
//
// in the engine each iteration passes through the three z multipliers
// (ST_MULT) and then the add and escape compare (ST_STEP); an escaping
// pixel then goes through ST_LOG and ST_COLOR, an inside pixel returns to idle
// the front end registers the index times step products and the queue buffers up to two points,
// so the next pixel is taken while the current one iterates
// rst is synchronous and clears the queue, the sequencer and the configuration registers
// results cannot be stalled; done is high for exactly one cycle per result
`default_nettype none

module mandelbrot_escape_time_pixel_core #(
  parameter int COORD_BITS    = mbrot_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = mbrot_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [COORD_BITS-1:0]            column,
  input  logic [COORD_BITS-1:0]            row,
  input  logic                             cfg_we,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             done,
  output logic [15:0]                      iterations,
  output logic                             inside_res,
  output logic [18:0]                      color
);
  import mbrot_pkg::*;

  qstat_t             qstat;
  cpoint_t            point;
  cpoint_t            qhead;
  logic               push;
  logic               pop;
  logic [LIMIT_W-1:0] iteration_limit;

  // pixel mapping and configuration
  mbrot_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .column          (column),
    .row             (row),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .qstat           (qstat),
    .push            (push),
    .point           (point),
    .iteration_limit (iteration_limit)
  );

  // point queue
  mbrot_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (point),
    .pop   (pop),
    .rdata (qhead),
    .stat  (qstat)
  );

  // escape iteration and coloring
  mbrot_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .iteration_limit (iteration_limit),
    .qhead           (qhead),
    .qstat           (qstat),
    .pop             (pop),
    .done            (done),
    .iterations      (iterations),
    .inside_res      (inside_res),
    .color           (color)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the mandelbrot escape time pixel core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrot_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam longint FOUR_Q = longint'(4) <<< FRAC;
  localparam logic [127:0] PROD_CAP = 128'd1 << 62;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [15:0] iters;
    logic        in_set;
    logic [18:0] shade;
  } pixel_result_t;

  // round(256 * ln(n)), entries 0 and 1 are zero
  int unsigned ln_q8_lut [64] = '{
    0, 0, 177, 281, 355, 412, 459, 498,
    532, 562, 589, 614, 636, 657, 676, 693,
    710, 725, 740, 754, 767, 779, 791, 803,
    814, 824, 834, 844, 853, 862, 871, 879,
    887, 895, 903, 910, 917, 924, 931, 938,
    944, 951, 957, 963, 969, 975, 980, 986,
    991, 996, 1001, 1007, 1012, 1016, 1021, 1026,
    1030, 1035, 1039, 1044, 1048, 1052, 1057, 1061
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [11:0]           column = '0;
  logic [11:0]           row = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [15:0]           iterations;
  logic                  inside_res;
  logic [18:0]           color;

  // shadow copy of the view registers, starts at the reset values
  logic signed [31:0] org_re = -32'sd644245094;
  logic signed [31:0] org_im = -32'sd322122547;
  logic signed [31:0] stp_re = 32'sd1342177;
  logic signed [31:0] stp_im = 32'sd1342177;
  logic [15:0]        iter_lim = 16'd100;

  pixel_t        pixel_queue [$];
  pixel_result_t predicted_escapes [$];

  int gap_left = 0;
  int idle_pct = 40;
  int mismatches = 0;
  int pixels_sent = 0;
  int inside_seen = 0;
  int escaped_seen = 0;
  int deepest_escape = 0;
  int views_set = 0;

  mandelbrot_escape_time_pixel_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .column     (column),
    .row        (row),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .iterations (iterations),
    .inside_res (inside_res),
    .color      (color)
  );

  always #4 clk = ~clk;

  // signed (a*b) >> sh with floor rounding and a cap on the magnitude
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int unsigned sh);
    logic signed [127:0] wa, wb, p;
    logic [127:0] mag, res;
    logic neg;
    wa = a;
    wb = b;
    p = wa * wb;
    neg = p[127];
    mag = neg ? -p : p;
    res = mag >> sh;
    if (res > PROD_CAP) res = PROD_CAP;
    if (neg && (mag & ((128'd1 << sh) - 128'd1)) != 0) res = res + 128'd1;
    scaled_product = neg ? -longint'(res[63:0]) : longint'(res[63:0]);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7fffffff)) clamp32 = longint'(32'sh7fffffff);
    else if (v < -longint'(64'sh80000000)) clamp32 = -longint'(64'sh80000000);
    else clamp32 = v;
  endfunction

  // escape time and smooth color of one pixel under the shadow view
  function automatic pixel_result_t escape_time(input logic [11:0] col,
                                                input logic [11:0] rw);
    longint cr, ci, zr, zi, nr, ni, sq_r, sq_i, abs2, whole, shade;
    int unsigned k, lg;
    logic escaped;
    pixel_result_t res;
    cr = clamp32(longint'(org_re) + longint'(col) * longint'(stp_re));
    ci = clamp32(longint'(org_im) + longint'(rw) * longint'(stp_im));
    zr = 0;
    zi = 0;
    sq_r = 0;
    sq_i = 0;
    abs2 = 0;
    k = 0;
    escaped = 1'b0;
    while (k < iter_lim && !escaped) begin
      nr = sq_r - sq_i + cr;
      ni = scaled_product(zr, zi, FRAC - 1) + ci;
      zr = nr;
      zi = ni;
      sq_r = scaled_product(zr, zr, FRAC);
      sq_i = scaled_product(zi, zi, FRAC);
      abs2 = sq_r + sq_i;
      if (abs2 >= FOUR_Q) escaped = 1'b1;
      else k++;
    end
    res.iters = k[15:0];
    res.in_set = !escaped;
    res.shade = '0;
    if (escaped) begin
      whole = abs2 >>> FRAC;
      lg = 0;
      while (whole > 1) begin
        whole = whole >>> 1;
        lg++;
      end
      shade = (longint'(255 + 5 * (k + 1)) <<< 8) - 5 * longint'(ln_q8_lut[lg & 63]);
      shade = shade >>> 8;
      res.shade = shade[18:0];
    end
    return res;
  endfunction

  // pixel driver: predicts each accepted transaction, then issues the next one
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        predicted_escapes.push_back(escape_time(column, row));
        pixels_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        nxt = pixel_queue.pop_front();
        column <= nxt.col;
        row <= nxt.row;
        start <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) begin
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: every done pulse is checked against the oldest prediction
  always @(posedge clk) begin : result_monitor
    pixel_result_t want;
    if (!rst && done) begin
      if (predicted_escapes.size() == 0) begin
        $error("unexpected result: iterations %0d inside_res %0d color %0d",
               iterations, inside_res, color);
        mismatches++;
      end else begin
        want = predicted_escapes.pop_front();
        if (iterations !== want.iters) begin
          $error("iterations: expected %0d, got %0d", want.iters, iterations);
          mismatches++;
        end
        if (inside_res !== want.in_set) begin
          $error("inside_res: expected %0d, got %0d", want.in_set, inside_res);
          mismatches++;
        end
        if (color !== want.shade) begin
          $error("color: expected %0d, got %0d", want.shade, color);
          mismatches++;
        end
        if (want.in_set) inside_seen++;
        else begin
          escaped_seen++;
          if (want.iters > deepest_escape) deepest_escape = want.iters;
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ORIGIN_REAL: org_re = val;
      REG_ORIGIN_IMAG: org_im = val;
      REG_STEP_REAL:   stp_re = val;
      REG_STEP_IMAG:   stp_im = val;
      REG_ITER_LIMIT:  iter_lim = val[15:0];
      default: ;
    endcase
  endtask

  // program a whole view; only called while the core is idle
  task automatic set_view(input logic [31:0] ore, input logic [31:0] oim,
                          input logic [31:0] sre, input logic [31:0] sim,
                          input logic [15:0] lim);
    write_reg(REG_ORIGIN_REAL, ore);
    write_reg(REG_ORIGIN_IMAG, oim);
    write_reg(REG_STEP_REAL, sre);
    write_reg(REG_STEP_IMAG, sim);
    write_reg(REG_ITER_LIMIT, {16'd0, lim});
    @(posedge clk);
    cfg_we <= 1'b0;
    views_set++;
    @(negedge clk);
  endtask

  task automatic queue_pixel(input int col, input int rw);
    pixel_queue.push_back('{col: col[11:0], row: rw[11:0]});
  endtask

  // hold off until every queued pixel is accepted and every result is back
  task automatic drain;
    do @(negedge clk);
    while (pixel_queue.size() != 0 || start || predicted_escapes.size() != 0);
  endtask

  initial begin : stimulus
    int ph, n;
    logic [31:0] s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default view: screen corners and two points inside the set
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(480, 240);
    queue_pixel(380, 240);
    drain();

    // extreme origins and steps so c saturates, single iteration
    set_view(32'h7fff0000, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'd1);
    queue_pixel(4095, 4095);
    queue_pixel(1, 1);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    drain();

    // zero limit: nothing iterates, every pixel reads as inside
    set_view(-32'sd644245094, -32'sd322122547, 32'sd1342177, 32'sd1342177, 16'd0);
    queue_pixel(0, 0);
    queue_pixel(480, 240);
    queue_pixel(4095, 4095);
    drain();

    // largest limit: one full-length inside pixel, the rest escape
    set_view(-32'sd134217728, 32'd0, 32'd1 << 20, 32'd1 << 20, 16'hffff);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(195, 0);
    queue_pixel(600, 0);
    queue_pixel(1000, 3000);
    drain();

    // random views with random pixels, each phase drained before the next
    for (ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 3 == 1) ? 0 : 40;
      case (ph % 4)
        0: set_view(-32'sd644245094, -32'sd322122547, 32'sd1342177, 32'sd1342177,
                    16'($urandom_range(1, 160)));
        1: begin
          s = $urandom_range(1024, 262144);
          set_view($urandom_range(0, 805306368) - 671088640,
                   $urandom_range(0, 536870912) - 402653184,
                   s, ($urandom_range(0, 3) == 0) ? -s : s,
                   16'($urandom_range(1, 128)));
        end
        2: set_view($urandom(), $urandom(), $urandom(), $urandom(),
                    16'($urandom_range(1, 48)));
        default: begin
          s = $urandom_range(64, 4096);
          set_view(-32'sd203004887 + $urandom_range(0, 1 << 20),
                   32'sd26843545 + $urandom_range(0, 1 << 20),
                   s, s, 16'($urandom_range(64, 160)));
        end
      endcase
      for (n = 0; n < 235; n++) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      drain();
    end

    // quiet tail to catch stray results
    repeat (2 * iter_lim + 16) @(posedge clk);
    if (predicted_escapes.size() != 0) begin
      $error("%0d results never arrived", predicted_escapes.size());
      mismatches++;
    end

    $display("%0d pixels over %0d views: %0d inside the set, %0d escaped",
             pixels_sent, views_set + 1, inside_seen, escaped_seen);
    $display("deepest escape at iteration %0d; limits 0, 1 and 65535 and clamped c covered",
             deepest_escape);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog against a hung core
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
